/* sv/oaht_pkg.sv */
package oaht_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 31;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int SIZE_W   = 11;
  localparam int BIT_W    = $clog2(KEY_BITS);

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1021);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_USED      = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef struct packed {
    op_t                 opcode;
    logic [KEY_BITS-1:0] key;
    logic [ADDR_W-1:0]   slot_index;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   position;
    status_t             status;
    logic [KEY_BITS-1:0] key_out;
  } out_t;

endpackage

/* sv/open_addressing_hash_table.sv */
// Insert, lookup: probe 1 up to table_size slots (table_size taken as 1..CAPACITY).
// Read slot: no memory access outside the table; clear: rewrites all CAPACITY slots.
// One item at a time; the key mod table_size takes one remainder bit a cycle and each
// probe passes S_PROBE and S_CHECK through the slot memory, all on one 12-bit subtract
// unit. After reset (rst_n low, synchronous) a clearing pass empties every slot before
// the first beat is taken; table_size resets to 1021.
module open_addressing_hash_table
  import oaht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_PROBE = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);

  logic [KEY_BITS:0] mem [CAPACITY];

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   table_size_r, table_size_nxt;
  op_t                 op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [SIZE_W-1:0]   probes_r, probes_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                clr_res_r, clr_res_nxt;
  out_t                res_r, res_nxt;
  out_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_BITS:0]   rd_data_r;

  logic [SIZE_W-1:0]   n_w, step_w, n_m1_w;
  logic [SIZE_W:0]     acc_w;
  logic                ge_w;
  logic [SIZE_W-1:0]   red_w;
  logic                used_w, match_w;
  logic [ADDR_W-1:0]   pos_w;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [KEY_BITS:0]   mem_wd;

  always_comb begin
    if (table_size_r == '0) begin
      n_w = SIZE_W'(1);
    end else if (table_size_r > SIZE_W'(CAPACITY)) begin
      n_w = SIZE_W'(CAPACITY);
    end else begin
      n_w = table_size_r;
    end
  end

  assign step_w = (n_w >> 1) + SIZE_W'(1);
  assign n_m1_w = n_w - SIZE_W'(1);
  assign pos_w  = rem_r[ADDR_W-1:0];

  // shared unit: remainder step while dividing, wrap after a probe step
  assign acc_w = (state_r == S_MOD) ? {rem_r, key_r[bit_r]}
                                    : ({1'b0, rem_r} + {1'b0, step_w});
  assign ge_w  = acc_w >= {1'b0, n_w};
  assign red_w = ge_w ? SIZE_W'(acc_w - {1'b0, n_w}) : acc_w[SIZE_W-1:0];

  assign used_w  = rd_data_r[KEY_BITS];
  assign match_w = rd_data_r[KEY_BITS-1:0] == key_r;

  always_comb begin
    state_nxt      = state_r;
    table_size_nxt = cfg_we ? cfg_wdata : table_size_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    probes_nxt     = probes_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_res_nxt    = clr_res_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_wa         = clr_cnt_r;
    mem_wd         = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_r == LAST_SLOT) begin
          clr_cnt_nxt = '0;
          clr_res_nxt = 1'b0;
          if (clr_res_r) begin
            res_nxt   = '{position: '0, status: ST_EMPTY, key_out: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.opcode;
          key_nxt = in_data.key;
          case (in_data.opcode)
            OP_INSERT, OP_LOOKUP: begin
              rem_nxt    = '0;
              bit_nxt    = BIT_W'(KEY_BITS - 1);
              probes_nxt = '0;
              state_nxt  = S_MOD;
            end
            OP_READ: begin
              rem_nxt    = SIZE_W'(in_data.slot_index);
              probes_nxt = '0;
              if (SIZE_W'(in_data.slot_index) >= n_w) begin
                res_nxt   = '{position: in_data.slot_index, status: ST_EMPTY, key_out: '0};
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_PROBE;
              end
            end
            OP_CLEAR: begin
              clr_res_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        rem_nxt = red_w;
        if (bit_r == '0) begin
          state_nxt = S_PROBE;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (op_r == OP_READ) begin
          if (used_w) begin
            res_nxt = '{position: pos_w, status: ST_USED, key_out: rd_data_r[KEY_BITS-1:0]};
          end else begin
            res_nxt = '{position: pos_w, status: ST_EMPTY, key_out: '0};
          end
        end else if (!used_w) begin
          if (op_r == OP_INSERT) begin
            mem_we  = 1'b1;
            mem_wa  = pos_w;
            mem_wd  = {1'b1, key_r};
            res_nxt = '{position: pos_w, status: ST_INSERTED, key_out: key_r};
          end else begin
            res_nxt = '{position: pos_w, status: ST_NOT_FOUND, key_out: '0};
          end
        end else if (match_w) begin
          res_nxt = '{position: pos_w,
                      status: (op_r == OP_INSERT) ? ST_PRESENT : ST_FOUND,
                      key_out: key_r};
        end else if (probes_r == n_m1_w) begin
          res_nxt = '{position: '0,
                      status: (op_r == OP_INSERT) ? ST_FULL : ST_NOT_FOUND,
                      key_out: '0};
        end else begin
          probes_nxt = probes_r + SIZE_W'(1);
          rem_nxt    = red_w;
          state_nxt  = S_PROBE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[pos_w];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      table_size_r <= TABLE_SIZE_RST;
      clr_cnt_r    <= '0;
      clr_res_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      table_size_r <= table_size_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_res_r    <= clr_res_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    probes_r <= probes_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while an item is in progress");

  a_slot_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> rem_r < n_w)
    else $error("probe slot outside the table");

  a_probe_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> probes_r < n_w)
    else $error("probe count beyond table size");

  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && state_nxt == S_IDLE |=> out_valid)
    else $error("result dropped on leaving done");
`endif

endmodule

/* bench/hash_table_checker.sv */
module hash_table_checker
  import oaht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_t              out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {WALK_EMPTY, WALK_HIT, WALK_LIMIT} walk_t;

  logic [SIZE_W-1:0]   table_size_q;
  logic [KEY_BITS-1:0] stored_key [CAPACITY];
  logic                slot_taken [CAPACITY];
  out_t                expected_results [$];

  function automatic int live_slots();
    if (table_size_q == 0) return 1;
    if (int'(table_size_q) > CAPACITY) return CAPACITY;
    return int'(table_size_q);
  endfunction

  function automatic walk_t walk_for(input logic [KEY_BITS-1:0] k, output int where);
    int n;
    int stride;
    int pos;
    n = live_slots();
    stride = n / 2 + 1;
    pos = int'(longint'(k) % n);
    for (int i = 0; i < n; i++) begin
      if (!slot_taken[pos]) begin
        where = pos;
        return WALK_EMPTY;
      end
      if (stored_key[pos] == k) begin
        where = pos;
        return WALK_HIT;
      end
      pos += stride;
      while (pos >= n) pos -= n;
    end
    where = 0;
    return WALK_LIMIT;
  endfunction

  function automatic out_t predict_result(in_t beat);
    out_t  r;
    walk_t w;
    int    where;
    r = '0;
    where = 0;
    case (beat.opcode)
      OP_INSERT: begin
        w = walk_for(beat.key, where);
        if (w == WALK_HIT) begin
          r = '{ADDR_W'(where), ST_PRESENT, beat.key};
        end else if (w == WALK_EMPTY) begin
          slot_taken[where] = 1'b1;
          stored_key[where] = beat.key;
          r = '{ADDR_W'(where), ST_INSERTED, beat.key};
        end else begin
          r = '{'0, ST_FULL, '0};
        end
      end
      OP_LOOKUP: begin
        w = walk_for(beat.key, where);
        if (w == WALK_HIT) begin
          r = '{ADDR_W'(where), ST_FOUND, beat.key};
        end else begin
          r = '{ADDR_W'(where), ST_NOT_FOUND, '0};
        end
      end
      OP_READ: begin
        if (int'(beat.slot_index) < live_slots() && slot_taken[beat.slot_index]) begin
          r = '{beat.slot_index, ST_USED, stored_key[beat.slot_index]};
        end else begin
          r = '{beat.slot_index, ST_EMPTY, '0};
        end
      end
      OP_CLEAR: begin
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        r = '{'0, ST_EMPTY, '0};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      table_size_q = TABLE_SIZE_RST;
      foreach (slot_taken[i]) begin
        slot_taken[i] = 1'b0;
        stored_key[i] = '0;
      end
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) table_size_q = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: position %0d status %0d key_out %0d",
                 out_data.position, out_data.status, out_data.key_out);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_data.position);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.key_out !== want.key_out) begin
            $error("key_out: expected %0d, actual %0d", want.key_out, out_data.key_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
      outstanding <= expected_results.size();
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  import oaht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  int                  fail_count;
  int                  pending_count;
  bit                  idle_on = 1'b1;
  int                  ready_hold = 0;
  int                  table_span = 1021;
  logic [KEY_BITS-1:0] key_pool [$];

  open_addressing_hash_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hash_table_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (fail_count),
    .outstanding (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // stall the result side in random bursts while idle_on is set
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready && $urandom_range(0, 1) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  task automatic issue_op(op_t op, logic [KEY_BITS-1:0] key, logic [ADDR_W-1:0] idx);
    in_t beat;
    beat.opcode = op;
    beat.key = key;
    beat.slot_index = idx;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic set_table_size(logic [SIZE_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value == 0) table_span = 1;
    else if (int'(value) > CAPACITY) table_span = CAPACITY;
    else table_span = int'(value);
  endtask

  task automatic run_random(int count);
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic [ADDR_W-1:0]   idx;
    int                  pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_INSERT;
      else if (pick < 75) op = OP_LOOKUP;
      else if (pick < 95) op = OP_READ;
      else op = OP_CLEAR;
      pick = $urandom_range(0, 99);
      if (pick < 30) key = KEY_BITS'($urandom);
      else if (pick < 60 && key_pool.size() != 0)
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else key = KEY_BITS'($urandom_range(0, 4 * table_span));
      if ($urandom_range(0, 1) == 0) idx = ADDR_W'($urandom_range(0, table_span - 1));
      else idx = ADDR_W'($urandom);
      issue_op(op, key, idx);
      if (op == OP_INSERT) begin
        key_pool.push_back(key);
        if (key_pool.size() > 48) void'(key_pool.pop_front());
      end else if (op == OP_CLEAR) begin
        key_pool.delete();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue_op(OP_INSERT, '0, '0);
    issue_op(OP_INSERT, '1, '1);
    issue_op(OP_INSERT, '0, '0);
    issue_op(OP_INSERT, KEY_BITS'(1021), '0);
    issue_op(OP_LOOKUP, KEY_BITS'(1021), '0);
    issue_op(OP_LOOKUP, KEY_BITS'(2042), '0);
    issue_op(OP_READ, '0, ADDR_W'(0));
    issue_op(OP_READ, '0, ADDR_W'(511));
    issue_op(OP_READ, '0, ADDR_W'(1));
    issue_op(OP_READ, '1, '1);
    issue_op(OP_CLEAR, '0, '0);
    issue_op(OP_LOOKUP, '0, '0);
    issue_op(OP_READ, '0, '0);

    // fill a small table along one probe chain
    set_table_size(SIZE_W'(11));
    for (int k = 0; k < 11; k++) issue_op(OP_INSERT, KEY_BITS'(k * 11 + 3), '0);
    issue_op(OP_INSERT, KEY_BITS'(11 * 11 + 3), '0);
    issue_op(OP_LOOKUP, KEY_BITS'(7), '0);
    issue_op(OP_LOOKUP, KEY_BITS'(10 * 11 + 3), '0);
    run_random(70);

    set_table_size(SIZE_W'(0));
    run_random(25);
    set_table_size(SIZE_W'(2047));
    run_random(50);
    set_table_size(SIZE_W'(13));
    run_random(90);
    set_table_size(SIZE_W'(1024));
    run_random(50);
    set_table_size(SIZE_W'(97));
    run_random(140);
    set_table_size(SIZE_W'(1021));
    run_random(60);
    set_table_size(SIZE_W'(31));
    idle_on <= 1'b0;
    run_random(80);

    drain_results();
    repeat (2200) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* open_addressing_hash_table.f */
sv/oaht_pkg.sv
sv/open_addressing_hash_table.sv
bench/hash_table_checker.sv
bench/testbench.sv
